>>> rtl/pfbb_pkg.sv
`timescale 1ns / 1ps
package pfbb_pkg;

	localparam int PALETTE_DEPTH_DEF = 256;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_DEPTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_FORMAT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PLANE_ALPHA = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANS_INDEX = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PAL_ENTRIES = 3'd5;

	localparam logic [2:0] FMT_GRAY    = 3'd0;
	localparam logic [2:0] FMT_PALETTE = 3'd1;
	localparam logic [2:0] FMT_PLANAR  = 3'd2;
	localparam logic [2:0] FMT_RGBA32  = 3'd3;
	localparam logic [2:0] FMT_RGB24   = 3'd4;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_RANGE  = 2'd1;
	localparam logic [1:0] ST_FORMAT = 2'd2;

	localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;
	localparam logic [7:0]  KEY_ACTIVE   = 8'hff;
	localparam logic [8:0]  INDEX_NONE   = 9'd256;
	localparam logic [8:0]  ENTRIES_ALL  = 9'd256;

	typedef struct packed {
		logic        we;
		logic [1:0]  status;
		logic        blend;
		logic [31:0] pix;
		logic [7:0]  alpha;
		logic [15:0] mr;
		logic [15:0] mg;
		logic [15:0] mb;
	} mid_t;

	function automatic logic [31:0] pack1555(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		return {16'h0000, 1'b1, r[7:3], g[7:3], b[7:3]};
	endfunction

	function automatic logic [31:0] pack8888(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [7:0] a);
		return {a, r, g, b};
	endfunction

	// exact for x up to 255*255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return t[15:8];
	endfunction

	function automatic logic [15:0] mix_sum(input logic [7:0] d, input logic [7:0] s,
			input logic [7:0] a);
		logic [15:0] pd;
		logic [15:0] ps;
		pd = {8'd0, d} * {8'd0, ALPHA_OPAQUE - a};
		ps = {8'd0, s} * {8'd0, a};
		return pd + ps;
	endfunction

endpackage

>>> rtl/pfbb_ram.sv
`timescale 1ns / 1ps
module pfbb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/pixel_format_blit_blend_top.sv
`timescale 1ns / 1ps
// Pixel blit stage: one transaction in and one transaction out per clock unless the output
// stalls. The three pipeline stages are the palette read (a registered RAM port), the blend
// multiply, and the divide-by-255 and final pack feeding the output register. The whole
// pipeline stalls only when the output holds a result that is not taken. A palette write
// transaction updates the entry in time for a palette pixel accepted in the very next cycle.
// Configuration writes are accepted every cycle and must only happen while the pipeline is
// empty. The palette has no reset: load every entry that a palette-format pixel can
// reference before drawing.
module pixel_format_blit_blend_top #(
	parameter int PALETTE_DEPTH = pfbb_pkg::PALETTE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pfbb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           func,
	input  logic [7:0]                     byte0,
	input  logic [7:0]                     byte1,
	input  logic [7:0]                     byte2,
	input  logic [7:0]                     byte3,
	input  logic [31:0]                    dest_pixel,
	input  logic [7:0]                     pal_addr,
	input  logic [23:0]                    pal_color,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           write_enable,
	output logic [31:0]                    out_pixel,
	output logic [1:0]                     status
);
	import pfbb_pkg::*;

	localparam int AW = $clog2(PALETTE_DEPTH);
	localparam logic [8:0] DEPTH9 = 9'(PALETTE_DEPTH);

	logic        out_depth_q;
	logic [2:0]  src_format_q;
	logic [7:0]  plane_alpha_q;
	logic [31:0] key_word_q;
	logic [8:0]  trans_index_q;
	logic [8:0]  pal_entries_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_depth_q   <= 1'b1;
			src_format_q  <= FMT_GRAY;
			plane_alpha_q <= ALPHA_OPAQUE;
			key_word_q    <= 32'd0;
			trans_index_q <= INDEX_NONE;
			pal_entries_q <= ENTRIES_ALL;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_OUT_DEPTH:   out_depth_q   <= cfg_data[0];
				CFG_SRC_FORMAT:  src_format_q  <= cfg_data[2:0];
				CFG_PLANE_ALPHA: plane_alpha_q <= cfg_data[7:0];
				CFG_KEY_WORD:    key_word_q    <= cfg_data;
				CFG_TRANS_INDEX: trans_index_q <= cfg_data[8:0];
				CFG_PAL_ENTRIES: pal_entries_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	logic adv;
	logic in_acc;

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;
	assign in_acc   = in_valid && adv;

	logic        pal_we;
	logic [23:0] pal_rdata;

	assign pal_we = in_acc && func && ({1'b0, pal_addr} < DEPTH9);

	pfbb_ram #(
		.WIDTH(24),
		.DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk  (clk),
		.we   (pal_we),
		.waddr(pal_addr[AW-1:0]),
		.wdata(pal_color),
		.re   (in_acc),
		.raddr(byte0[AW-1:0]),
		.rdata(pal_rdata)
	);

	// stage 1
	logic        valid_s1;
	logic        func_s1;
	logic [7:0]  b0_s1;
	logic [7:0]  b1_s1;
	logic [7:0]  b2_s1;
	logic [7:0]  b3_s1;
	logic [31:0] dest_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1 <= func;
			b0_s1   <= byte0;
			b1_s1   <= byte1;
			b2_s1   <= byte2;
			b3_s1   <= byte3;
			dest_s1 <= dest_pixel;
		end
	end

	mid_t        mid;
	logic [7:0]  pr;
	logic [7:0]  pg;
	logic [7:0]  pb;
	logic        keyed;
	logic [7:0]  a_out;

	assign pr    = pal_rdata[23:16];
	assign pg    = pal_rdata[15:8];
	assign pb    = pal_rdata[7:0];
	assign keyed = (key_word_q[31:24] == KEY_ACTIVE) &&
		({b0_s1, b1_s1, b2_s1} == key_word_q[23:0]);
	assign a_out = (plane_alpha_q != ALPHA_OPAQUE) ? plane_alpha_q : b0_s1;

	always_comb begin
		mid        = '0;
		mid.mr     = mix_sum(dest_s1[23:16], b3_s1, b0_s1);
		mid.mg     = mix_sum(dest_s1[15:8], b2_s1, b0_s1);
		mid.mb     = mix_sum(dest_s1[7:0], b1_s1, b0_s1);
		mid.alpha  = (plane_alpha_q != ALPHA_OPAQUE) ? plane_alpha_q : dest_s1[31:24];
		if (!func_s1) begin
			unique case (src_format_q)
				FMT_GRAY: begin
					mid.we  = 1'b1;
					mid.pix = out_depth_q ? pack8888(b0_s1, b0_s1, b0_s1, plane_alpha_q)
						: pack1555(b0_s1, b0_s1, b0_s1);
				end
				FMT_PALETTE: begin
					if ({1'b0, b0_s1} == trans_index_q) begin
						mid.we = 1'b0;
					end else if (({1'b0, b0_s1} >= pal_entries_q) ||
							({1'b0, b0_s1} >= DEPTH9)) begin
						mid.status = ST_RANGE;
					end else begin
						mid.we  = 1'b1;
						mid.pix = out_depth_q ? pack8888(pr, pg, pb, plane_alpha_q)
							: pack1555(pr, pg, pb);
					end
				end
				FMT_PLANAR: begin
					if (!out_depth_q) begin
						mid.we  = 1'b1;
						mid.pix = pack1555(b0_s1, b1_s1, b2_s1);
					end else if (!keyed) begin
						mid.we  = 1'b1;
						mid.pix = pack8888(b0_s1, b1_s1, b2_s1, plane_alpha_q);
					end
				end
				FMT_RGBA32: begin
					if (!out_depth_q) begin
						if (b3_s1 != 8'd0) begin
							mid.we  = 1'b1;
							mid.pix = pack1555(b0_s1, b1_s1, b2_s1);
						end
					end else if (b0_s1 != 8'd0) begin
						mid.we = 1'b1;
						if (b0_s1 != ALPHA_OPAQUE && dest_s1[31:24] != 8'd0) begin
							mid.blend = 1'b1;
						end else begin
							mid.pix = pack8888(b3_s1, b2_s1, b1_s1, a_out);
						end
					end
				end
				FMT_RGB24: begin
					if (out_depth_q) begin
						mid.we  = 1'b1;
						mid.pix = pack8888(b2_s1, b1_s1, b0_s1, plane_alpha_q);
					end else begin
						mid.status = ST_FORMAT;
					end
				end
				default: begin
					mid.status = ST_FORMAT;
				end
			endcase
		end
	end

	// stage 2
	logic valid_s2;
	mid_t mid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mid_s2 <= mid;
		end
	end

	logic [31:0] pix_fin;

	assign pix_fin = mid_s2.blend ? pack8888(div255(mid_s2.mr), div255(mid_s2.mg),
		div255(mid_s2.mb), mid_s2.alpha) : mid_s2.pix;

	// stage 3, output register
	logic        valid_s3;
	logic        we_s3;
	logic [31:0] pix_s3;
	logic [1:0]  status_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			we_s3     <= mid_s2.we;
			pix_s3    <= mid_s2.we ? pix_fin : 32'd0;
			status_s3 <= mid_s2.status;
		end
	end

	assign out_valid    = valid_s3;
	assign write_enable = we_s3;
	assign out_pixel    = pix_s3;
	assign status       = status_s3;

endmodule

>>> test/pixel_format_blit_blend_top_test.sv
`timescale 1ns / 1ps
module pixel_format_blit_blend_top_test;
	import pfbb_pkg::*;

	localparam int PAL_DEPTH = PALETTE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 300000;
	localparam int RX_LONG_HOLD = 400;
	localparam int PHASE_ITEMS = 84;
	localparam int NUM_PHASES = 22;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS = 200;
	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_PAL_WRITE = 1'b1;
	localparam logic [2:0] FMT_LAST_CODE = 3'd7;
	localparam logic [2:0] FMT_CYCLE [5] = '{FMT_GRAY, FMT_PALETTE, FMT_PLANAR, FMT_RGBA32,
		FMT_RGB24};

	typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY} rx_mode_t;

	typedef struct packed {
		logic        func;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [7:0]  b3;
		logic [31:0] dest;
		logic [7:0]  pal_addr;
		logic [23:0] pal_color;
	} blit_item_t;

	typedef struct packed {
		logic        we;
		logic [31:0] pix;
		logic [1:0]  st;
	} blit_result_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 func = 1'b0;
	logic [7:0]           byte0 = '0;
	logic [7:0]           byte1 = '0;
	logic [7:0]           byte2 = '0;
	logic [7:0]           byte3 = '0;
	logic [31:0]          dest_pixel = '0;
	logic [7:0]           pal_addr = '0;
	logic [23:0]          pal_color = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 write_enable;
	logic [31:0]          out_pixel;
	logic [1:0]           status;

	// predictor copy of the registers and palette
	logic        m_depth = 1'b1;
	logic [2:0]  m_format = FMT_GRAY;
	logic [7:0]  m_alpha = ALPHA_OPAQUE;
	logic [31:0] m_key = '0;
	logic [8:0]  m_trans = INDEX_NONE;
	logic [8:0]  m_entries = ENTRIES_ALL;
	logic [23:0] pal_model [PAL_DEPTH];

	// stimulus side view of the registers and of loaded palette entries
	logic [2:0]  g_format = FMT_GRAY;
	logic [31:0] g_key = '0;
	logic [8:0]  g_trans = INDEX_NONE;
	logic [8:0]  g_entries = ENTRIES_ALL;
	logic        pal_loaded [PAL_DEPTH];
	logic [7:0]  loaded_list [$];

	blit_item_t   pixel_stream [$];
	blit_result_t expected_writes [$];

	int       n_queued = 0;
	int       n_accepted = 0;
	int       n_cfg_done = 0;
	int       mismatch_cnt = 0;
	int       cycle_cnt = 0;
	logic     in_taken = 1'b0;
	logic     tx_bursty = 1'b0;
	int       burst_left = 0;
	int       gap_left = 0;
	rx_mode_t rx_mode = RX_FREE;
	int       rx_hold_req = 0;
	int       rx_hold_served = 0;
	int       rx_long_left = 0;
	int       rx_stall_left = 0;

	pixel_format_blit_blend_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.byte0       (byte0),
		.byte1       (byte1),
		.byte2       (byte2),
		.byte3       (byte3),
		.dest_pixel  (dest_pixel),
		.pal_addr    (pal_addr),
		.pal_color   (pal_color),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.write_enable(write_enable),
		.out_pixel   (out_pixel),
		.status      (status)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [31:0] argb1555(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		return 32'h8000 | (32'(r >> 3) << 10) | (32'(g >> 3) << 5) | 32'(b >> 3);
	endfunction

	function automatic logic [7:0] blend_chan(input logic [7:0] d, input logic [7:0] s,
			input logic [7:0] a);
		int acc;
		acc = int'(d) * (255 - int'(a)) + int'(s) * int'(a);
		return 8'(acc / 255);
	endfunction

	task automatic predict_blit(input blit_item_t it);
		blit_result_t res;
		logic [7:0]   r;
		logic [7:0]   g;
		logic [7:0]   b;
		logic [7:0]   a;
		logic [23:0]  c;
		res = '0;
		if (it.func == FUNC_PAL_WRITE) begin
			pal_model[it.pal_addr] = it.pal_color;
		end else begin
			case (m_format)
				FMT_GRAY: begin
					res.we = 1'b1;
					res.pix = m_depth ? {m_alpha, it.b0, it.b0, it.b0} :
						argb1555(it.b0, it.b0, it.b0);
				end
				FMT_PALETTE: begin
					if (it.b0 != m_trans) begin
						if (it.b0 >= m_entries || it.b0 >= PAL_DEPTH) begin
							res.st = ST_RANGE;
						end else begin
							c = pal_model[it.b0];
							res.we = 1'b1;
							res.pix = m_depth ? {m_alpha, c} :
								argb1555(c[23:16], c[15:8], c[7:0]);
						end
					end
				end
				FMT_PLANAR: begin
					if (!m_depth) begin
						res.we = 1'b1;
						res.pix = argb1555(it.b0, it.b1, it.b2);
					end else if (!(m_key[31:24] == KEY_ACTIVE &&
							{it.b0, it.b1, it.b2} == m_key[23:0])) begin
						res.we = 1'b1;
						res.pix = {m_alpha, it.b0, it.b1, it.b2};
					end
				end
				FMT_RGBA32: begin
					if (!m_depth) begin
						if (it.b3 != 0) begin
							res.we = 1'b1;
							res.pix = argb1555(it.b0, it.b1, it.b2);
						end
					end else if (it.b0 != 0) begin
						a = it.b0;
						r = it.b3;
						g = it.b2;
						b = it.b1;
						if (a != ALPHA_OPAQUE && it.dest[31:24] != 0) begin
							r = blend_chan(it.dest[23:16], r, a);
							g = blend_chan(it.dest[15:8], g, a);
							b = blend_chan(it.dest[7:0], b, a);
							a = it.dest[31:24];
						end
						if (m_alpha != ALPHA_OPAQUE)
							a = m_alpha;
						res.we = 1'b1;
						res.pix = {a, r, g, b};
					end
				end
				FMT_RGB24: begin
					if (m_depth) begin
						res.we = 1'b1;
						res.pix = {m_alpha, it.b2, it.b1, it.b0};
					end else begin
						res.st = ST_FORMAT;
					end
				end
				default: res.st = ST_FORMAT;
			endcase
		end
		expected_writes.push_back(res);
	endtask

	task automatic flag_mismatch(input string msg);
		if (mismatch_cnt < MAX_REPORTS)
			$display("%0t ns mismatch: %s", $time, msg);
		mismatch_cnt++;
	endtask

	always @(posedge clk) begin : check_results
		blit_result_t want;
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("pixel_format_blit_blend_top_test: FAIL");
			$finish;
		end else begin
			in_taken <= in_valid && in_ready;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_OUT_DEPTH:   m_depth = cfg_data[0];
					CFG_SRC_FORMAT:  m_format = cfg_data[2:0];
					CFG_PLANE_ALPHA: m_alpha = cfg_data[7:0];
					CFG_KEY_WORD:    m_key = cfg_data;
					CFG_TRANS_INDEX: m_trans = cfg_data[8:0];
					CFG_PAL_ENTRIES: m_entries = cfg_data[8:0];
					default: ;
				endcase
				n_cfg_done++;
			end
			if (in_valid && in_ready) begin
				predict_blit(blit_item_t'({func, byte0, byte1, byte2, byte3, dest_pixel,
					pal_addr, pal_color}));
				n_accepted++;
			end
			if (out_valid && out_ready) begin
				if (expected_writes.size() == 0) begin
					flag_mismatch($sformatf("result with nothing expected: we %0b pix %h st %0d",
						write_enable, out_pixel, status));
				end else begin
					want = expected_writes.pop_front();
					if (write_enable !== want.we)
						flag_mismatch($sformatf("write_enable %0b, expected %0b",
							write_enable, want.we));
					if (out_pixel !== want.pix)
						flag_mismatch($sformatf("out_pixel %h, expected %h", out_pixel,
							want.pix));
					if (status !== want.st)
						flag_mismatch($sformatf("status %0d, expected %0d", status, want.st));
				end
			end
		end
	end

	// input driver: bursts with random gaps when tx_bursty is set
	always @(negedge clk) begin : drive_items
		blit_item_t nxt;
		if (arst_n && (!in_valid || in_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pixel_stream.size() != 0) begin
				nxt = pixel_stream.pop_front();
				func <= nxt.func;
				byte0 <= nxt.b0;
				byte1 <= nxt.b1;
				byte2 <= nxt.b2;
				byte3 <= nxt.b3;
				dest_pixel <= nxt.dest;
				pal_addr <= nxt.pal_addr;
				pal_color <= nxt.pal_color;
				in_valid <= 1'b1;
				if (tx_bursty) begin
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 24);
						gap_left = $urandom_range(1, 8);
					end
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver with its own stall pattern and an occasional long hold
	always @(negedge clk) begin : accept_results
		if (rx_hold_served != rx_hold_req) begin
			rx_hold_served++;
			rx_long_left = RX_LONG_HOLD;
		end
		if (rx_long_left > 0) begin
			rx_long_left--;
			out_ready <= 1'b0;
		end else if (rx_mode == RX_FREE) begin
			out_ready <= 1'b1;
		end else if (rx_stall_left > 0) begin
			rx_stall_left--;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 99) < ((rx_mode == RX_LIGHT) ? 15 : 40)) begin
			rx_stall_left = $urandom_range(0, 7);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic queue_item(input blit_item_t it);
		if (it.func == FUNC_PAL_WRITE && !pal_loaded[it.pal_addr]) begin
			pal_loaded[it.pal_addr] = 1'b1;
			loaded_list.push_back(it.pal_addr);
		end
		pixel_stream.push_back(it);
		n_queued++;
	endtask

	task automatic wait_idle();
		while (n_accepted != n_queued || expected_writes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		int target;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		target = n_cfg_done + 1;
		do @(negedge clk); while (n_cfg_done < target);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_SRC_FORMAT:  g_format = val[2:0];
			CFG_KEY_WORD:    g_key = val;
			CFG_TRANS_INDEX: g_trans = val[8:0];
			CFG_PAL_ENTRIES: g_entries = val[8:0];
			default: ;
		endcase
	endtask

	function automatic blit_item_t pixel_item(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3, input logic [31:0] dest);
		blit_item_t it;
		it.func = FUNC_PIXEL;
		it.b0 = b0;
		it.b1 = b1;
		it.b2 = b2;
		it.b3 = b3;
		it.dest = dest;
		it.pal_addr = 8'($urandom);
		it.pal_color = 24'($urandom);
		return it;
	endfunction

	function automatic blit_item_t pal_item(input logic [7:0] addr, input logic [23:0] color);
		blit_item_t it;
		it = pixel_item(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), $urandom);
		it.func = FUNC_PAL_WRITE;
		it.pal_addr = addr;
		it.pal_color = color;
		return it;
	endfunction

	// never lets a palette pixel read an entry that was not loaded
	function automatic logic [7:0] pick_index();
		int         roll;
		logic [7:0] idx;
		roll = $urandom_range(0, 99);
		if (roll < 10 && g_trans < INDEX_NONE)
			return g_trans[7:0];
		if (roll < 25 && g_entries < ENTRIES_ALL)
			return 8'($urandom_range(int'(g_entries), 255));
		idx = 8'($urandom);
		if (idx == g_trans || idx >= g_entries || pal_loaded[idx])
			return idx;
		return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
	endfunction

	task automatic gen_random(input int n);
		blit_item_t it;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 12) begin
				it = pal_item(8'($urandom), 24'($urandom));
			end else begin
				it = pixel_item(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
					$urandom);
				case (g_format)
					FMT_PALETTE: it.b0 = pick_index();
					FMT_PLANAR: begin
						if ($urandom_range(0, 4) == 0)
							{it.b0, it.b1, it.b2} = g_key[23:0];
					end
					FMT_RGBA32: begin
						case ($urandom_range(0, 4))
							0: it.b0 = 8'h00;
							1: it.b0 = ALPHA_OPAQUE;
							default: ;
						endcase
						if ($urandom_range(0, 3) == 0)
							it.dest[31:24] = 8'h00;
						if ($urandom_range(0, 3) == 0)
							it.b3 = 8'h00;
					end
					default: ;
				endcase
			end
			queue_item(it);
		end
	endtask

	task automatic phase_config(input int k);
		logic [31:0] key;
		logic [8:0]  entries;
		logic [8:0]  trans;
		logic [7:0]  alpha;
		case ($urandom_range(0, 3))
			0, 1: key = {KEY_ACTIVE, 24'($urandom)};
			2: key = $urandom;
			default: key = k[0] ? 32'hffffffff : {KEY_ACTIVE, 24'h000000};
		endcase
		case (k % 4)
			0: begin alpha = ALPHA_OPAQUE; trans = INDEX_NONE; end
			1: begin alpha = 8'h00; trans = 9'd0; end
			2: begin alpha = 8'($urandom); trans = 9'd255; end
			default: begin alpha = ALPHA_OPAQUE - 8'd1; trans = 9'($urandom_range(0, 255)); end
		endcase
		case ((k / 5) % 4)
			0: entries = ENTRIES_ALL;
			1: entries = 9'($urandom_range(1, 255));
			2: entries = 9'd0;
			default: entries = 9'($urandom_range(0, int'(ENTRIES_ALL)));
		endcase
		if (k >= 20) begin
			set_reg(CFG_OUT_DEPTH, 32'(k % 2));
			set_reg(CFG_SRC_FORMAT, 32'($urandom_range(int'(FMT_RGB24) + 1,
				int'(FMT_LAST_CODE))));
		end else begin
			set_reg(CFG_OUT_DEPTH, 32'((k / 5) % 2));
			set_reg(CFG_SRC_FORMAT, 32'(FMT_CYCLE[k % 5]));
		end
		set_reg(CFG_PLANE_ALPHA, 32'(alpha));
		set_reg(CFG_KEY_WORD, key);
		set_reg(CFG_TRANS_INDEX, 32'(trans));
		set_reg(CFG_PAL_ENTRIES, 32'(entries));
	endtask

	initial begin
		for (int i = 0; i < PAL_DEPTH; i++)
			pal_loaded[i] = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: gray at 32 bits, then palette loads
		tx_bursty = 1'b0;
		rx_mode = RX_FREE;
		queue_item(pixel_item(8'h00, 8'($urandom), 8'($urandom), 8'($urandom), $urandom));
		queue_item(pixel_item(8'hff, 8'($urandom), 8'($urandom), 8'($urandom), $urandom));
		queue_item(pal_item(8'h00, 24'h000000));
		queue_item(pal_item(8'hff, 24'hffffff));
		queue_item(pal_item(8'h07, 24'h123456));
		queue_item(pal_item(8'h10, 24'h89abcd));
		wait_idle();

		// palette lookup, transparent index and bound
		set_reg(CFG_SRC_FORMAT, 32'(FMT_PALETTE));
		set_reg(CFG_TRANS_INDEX, 32'd7);
		set_reg(CFG_PAL_ENTRIES, 32'd200);
		queue_item(pixel_item(8'h00, 8'h11, 8'h22, 8'h33, $urandom));
		queue_item(pixel_item(8'h07, 8'h11, 8'h22, 8'h33, $urandom));
		queue_item(pixel_item(8'd200, 8'h11, 8'h22, 8'h33, $urandom));
		queue_item(pixel_item(8'hff, 8'h11, 8'h22, 8'h33, $urandom));
		wait_idle();
		set_reg(CFG_OUT_DEPTH, 32'd0);
		queue_item(pixel_item(8'h10, 8'h00, 8'h00, 8'h00, $urandom));
		wait_idle();

		// colour key on planar rgb
		set_reg(CFG_OUT_DEPTH, 32'd1);
		set_reg(CFG_SRC_FORMAT, 32'(FMT_PLANAR));
		set_reg(CFG_KEY_WORD, 32'hff123456);
		set_reg(CFG_PLANE_ALPHA, 32'h80);
		queue_item(pixel_item(8'h12, 8'h34, 8'h56, 8'($urandom), $urandom));
		queue_item(pixel_item(8'h12, 8'h34, 8'h57, 8'($urandom), $urandom));
		wait_idle();

		// rgba32: zero alpha, opaque, partial alpha with and without destination alpha
		set_reg(CFG_SRC_FORMAT, 32'(FMT_RGBA32));
		set_reg(CFG_PLANE_ALPHA, 32'(ALPHA_OPAQUE));
		queue_item(pixel_item(8'h00, 8'haa, 8'hbb, 8'hcc, 32'hff102030));
		queue_item(pixel_item(8'hff, 8'haa, 8'hbb, 8'hcc, 32'hff102030));
		queue_item(pixel_item(8'h80, 8'haa, 8'hbb, 8'hcc, 32'h00102030));
		queue_item(pixel_item(8'h80, 8'haa, 8'hbb, 8'hcc, 32'h40abcdef));
		queue_item(pixel_item(8'h01, 8'hff, 8'h00, 8'hff, 32'hff808080));
		wait_idle();
		set_reg(CFG_OUT_DEPTH, 32'd0);
		queue_item(pixel_item(8'h12, 8'h34, 8'h56, 8'h00, $urandom));
		queue_item(pixel_item(8'h12, 8'h34, 8'h56, 8'h05, $urandom));
		wait_idle();

		// unsupported formats, then rgb24 at 32 bits
		set_reg(CFG_SRC_FORMAT, 32'(FMT_RGB24));
		queue_item(pixel_item(8'h01, 8'h02, 8'h03, 8'h04, $urandom));
		wait_idle();
		set_reg(CFG_SRC_FORMAT, 32'(FMT_RGB24 + 1));
		queue_item(pixel_item(8'h01, 8'h02, 8'h03, 8'h04, $urandom));
		wait_idle();
		set_reg(CFG_SRC_FORMAT, 32'(FMT_LAST_CODE));
		queue_item(pixel_item(8'h01, 8'h02, 8'h03, 8'h04, $urandom));
		wait_idle();
		set_reg(CFG_OUT_DEPTH, 32'd1);
		set_reg(CFG_SRC_FORMAT, 32'(FMT_RGB24));
		queue_item(pixel_item(8'h01, 8'h02, 8'h03, 8'h04, $urandom));
		wait_idle();

		for (int k = 0; k < NUM_PHASES; k++) begin
			phase_config(k);
			tx_bursty = (k % 3) != 0;
			rx_mode = rx_mode_t'((k + 1) % 3);
			if (k == 9) begin
				gen_random(PHASE_ITEMS / 2);
				wait_idle();
				gen_random(PHASE_ITEMS - PHASE_ITEMS / 2);
			end else begin
				gen_random(PHASE_ITEMS);
				if (k == 5)
					rx_hold_req++;
			end
			wait_idle();
		end

		wait_idle();
		if (mismatch_cnt == 0)
			$display("pixel_format_blit_blend_top_test: PASS");
		else
			$display("pixel_format_blit_blend_top_test: FAIL");
		$finish;
	end

endmodule
